// ===== hw/rtl/lfu_pkg.sv =====
// Shared types and constants for the LFU key/value store.
`timescale 1ns / 1ps
package lfu_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CAP_W          = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    typedef struct packed {
        logic              command;
        logic signed [31:0] lookup_key;
        logic signed [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic signed [31:0] read_value;
        logic              evicted;
        logic signed [31:0] evicted_key;
    } rsp_t;

endpackage

// ===== hw/rtl/lfu_cache_replacement.sv =====
// Top level of the LFU key/value store with LRU tie-breaking.
`timescale 1ns / 1ps
// Each request runs a lookup pass, a decision step, an optional update pass and the output step.
// A get miss, or a set while the capacity is zero, skips the update pass.
// Each pass walks the single entry memory one row per cycle. The input is stalled until the
// result is loaded into the output register, so a new request is only taken once the last
// one is through, and a result stalled at the output holds up the next one.
// Reset clears all valid bits, the occupancy and the control state; the capacity register
// returns to 16. The entry memory itself is not cleared; a row's contents are used only once written.
module lfu_cache_replacement #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  lfu_pkg::req_t             in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output lfu_pkg::rsp_t             out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PTR_W = $clog2(ENTRIES + 1) + 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lfu_pkg::CAP_W) ? OCC_W + 1 : lfu_pkg::CAP_W + 1;
    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(ENTRIES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Controller states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_UPD    = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    // One memory row holds everything kept per entry except its valid bit.
    typedef struct packed {
        logic [31:0]           key;
        logic [31:0]           value;
        logic [COUNT_BITS-1:0] count;
        logic [IDX_W-1:0]      rank;
    } row_t;

    row_t mem [ENTRIES];

    logic [2:0]               state_reg, state_next;
    logic [PTR_W-1:0]         ptr_reg;
    logic                     rd_vld_reg;
    logic [IDX_W-1:0]         rd_idx_reg;
    row_t                     rd_row_reg;
    logic [ENTRIES-1:0]       valid_reg;
    logic [OCC_W-1:0]         occ_reg;
    logic [lfu_pkg::CAP_W-1:0] cap_reg;
    lfu_pkg::req_t            req_reg;

    // Results of the lookup pass.
    logic                     match_reg;
    logic [IDX_W-1:0]         match_idx_reg;
    logic [IDX_W-1:0]         match_rank_reg;
    logic [31:0]              match_val_reg;
    logic                     vic_reg;
    logic [IDX_W-1:0]         vic_idx_reg;
    logic [IDX_W-1:0]         vic_rank_reg;
    logic [COUNT_BITS-1:0]    vic_cnt_reg;
    logic [31:0]              vic_key_reg;
    logic                     free_reg;
    logic [IDX_W-1:0]         free_idx_reg;

    // Decisions taken between the two passes.
    logic                     ins_reg;
    logic                     evict_reg;
    logic [IDX_W-1:0]         ins_idx_reg;
    lfu_pkg::rsp_t            rsp_reg;
    logic                     out_valid_reg;

    logic                     sweep;
    logic                     sweep_done;
    logic                     rd_entry_valid;
    logic [CMP_W-1:0]         cap_eff;
    logic                     cap_zero;
    logic                     is_set;
    logic                     do_evict;
    logic                     do_upd;
    logic [IDX_W-1:0]         ins_idx;
    row_t                     wb_row;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    // Both passes walk the memory with the same pointer: issue a read for one row per cycle
    // and handle the row that came back from the previous cycle.
    assign sweep          = (state_reg == ST_SCAN) || (state_reg == ST_UPD);
    assign sweep_done     = (ptr_reg == PTR_END) && !rd_vld_reg;
    assign rd_entry_valid = valid_reg[rd_idx_reg];

    // A capacity above the number of entries acts as the number of entries.
    always_comb
    begin
        if (CMP_W'(cap_reg) > CMP_W'(ENTRIES))
            cap_eff = CMP_W'(ENTRIES);
        else
            cap_eff = CMP_W'(cap_reg);
    end

    assign cap_zero = (cap_eff == '0);
    assign is_set   = (req_reg.command == lfu_pkg::CMD_SET);
    assign do_evict = is_set && !cap_zero && !match_reg && vic_reg
                      && (CMP_W'(occ_reg) >= cap_eff);
    assign do_upd   = match_reg ? (!is_set || !cap_zero) : (is_set && !cap_zero);

    // The freed victim row is reused when no row is empty or it lies below the first empty row.
    always_comb
    begin
        if (do_evict && (!free_reg || (vic_idx_reg < free_idx_reg)))
            ins_idx = vic_idx_reg;
        else
            ins_idx = free_idx_reg;
    end

    // Row rewritten during the update pass. Valid bits already show the state after this
    // item, so an inserted row is recognised by its index rather than its valid bit.
    always_comb
    begin
        wb_row = rd_row_reg;
        if (ins_reg)
        begin
            if (rd_idx_reg == ins_idx_reg)
            begin
                wb_row.key   = req_reg.lookup_key;
                wb_row.value = req_reg.write_value;
                wb_row.count = COUNT_BITS'(1);
                wb_row.rank  = '0;
            end
            else if (rd_entry_valid)
            begin
                wb_row.rank = rd_row_reg.rank + IDX_W'(1)
                              - IDX_W'(evict_reg && (rd_row_reg.rank > vic_rank_reg));
            end
        end
        else
        begin
            if (rd_idx_reg == match_idx_reg)
            begin
                wb_row.rank = '0;
                if (rd_row_reg.count != COUNT_MAX)
                    wb_row.count = rd_row_reg.count + COUNT_BITS'(1);
                if (is_set)
                    wb_row.value = req_reg.write_value;
            end
            else if (rd_entry_valid && (rd_row_reg.rank < match_rank_reg))
            begin
                wb_row.rank = rd_row_reg.rank + IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_SCAN;
            ST_SCAN:   if (sweep_done) state_next = ST_DECIDE;
            ST_DECIDE: state_next = do_upd ? ST_UPD : ST_OUT;
            ST_UPD:    if (sweep_done) state_next = ST_OUT;
            ST_OUT:    if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Entry memory: one read and one write per cycle, read data registered.
    always_ff @(posedge clk)
    begin
        rd_row_reg <= mem[ptr_reg[IDX_W-1:0]];
        if ((state_reg == ST_UPD) && rd_vld_reg)
            mem[rd_idx_reg] <= wb_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            valid_reg     <= '0;
            occ_reg       <= '0;
            cap_reg       <= lfu_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;

            rd_vld_reg <= sweep && (ptr_reg != PTR_END);
            if (sweep && (ptr_reg != PTR_END))
                ptr_reg <= ptr_reg + PTR_W'(1);
            else if (sweep_done || (state_reg == ST_IDLE))
                ptr_reg <= '0;

            if (state_reg == ST_DECIDE && do_upd && !match_reg)
            begin
                if (do_evict)
                    valid_reg[vic_idx_reg] <= 1'b0;
                valid_reg[ins_idx] <= 1'b1;
                if (!do_evict)
                    occ_reg <= occ_reg + OCC_W'(1);
            end

            // A new result is offered once the previous one has been taken.
            if ((state_reg == ST_OUT) && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload and pass bookkeeping; no reset needed.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            req_reg   <= in_data;
            match_reg <= 1'b0;
            vic_reg   <= 1'b0;
            free_reg  <= 1'b0;
        end

        if ((state_reg == ST_SCAN) && rd_vld_reg)
        begin
            if (rd_entry_valid && (rd_row_reg.key == req_reg.lookup_key))
            begin
                match_reg      <= 1'b1;
                match_idx_reg  <= rd_idx_reg;
                match_rank_reg <= rd_row_reg.rank;
                match_val_reg  <= rd_row_reg.value;
            end
            // Lowest count wins; among equal counts the oldest (largest rank).
            if (rd_entry_valid && (!vic_reg || (rd_row_reg.count < vic_cnt_reg)
                || ((rd_row_reg.count == vic_cnt_reg) && (rd_row_reg.rank > vic_rank_reg))))
            begin
                vic_reg      <= 1'b1;
                vic_idx_reg  <= rd_idx_reg;
                vic_rank_reg <= rd_row_reg.rank;
                vic_cnt_reg  <= rd_row_reg.count;
                vic_key_reg  <= rd_row_reg.key;
            end
            if (!rd_entry_valid && !free_reg)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
        end

        if (sweep)
            rd_idx_reg <= ptr_reg[IDX_W-1:0];

        if (state_reg == ST_DECIDE)
        begin
            ins_reg     <= !match_reg;
            evict_reg   <= do_evict;
            ins_idx_reg <= ins_idx;
        end

        // The result register is only loaded once the previous result has left it.
        if ((state_reg == ST_OUT) && (!out_valid_reg || !out_stall))
        begin
            rsp_reg.hit         <= match_reg;
            rsp_reg.read_value  <= (match_reg && !is_set) ? match_val_reg : '1;
            rsp_reg.evicted     <= evict_reg;
            rsp_reg.evicted_key <= evict_reg ? vic_key_reg : '0;
        end
    end

    // The number of valid entries always equals the occupancy count.
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(occ_reg))
        else $error("occupancy differs from valid bit count");

    // An eviction only ever comes from a set miss.
    a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.hit && out_data.evicted))
        else $error("eviction reported on a hit");

    // Occupancy grows by at most one per item and never past the entry count.
    a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(occ_reg) <= ENTRIES) && (occ_reg <= $past(occ_reg) + OCC_W'(1)))
        else $error("occupancy out of range");

endmodule
